// ===== rtl/tsa_pkg.sv =====
// Package: shared widths, register indexes, reset values and config type for the swizzle block.
package tsa_pkg;

    localparam int MAX_DIM_LOG2_DEF = 11;
    localparam int PIXEL_W          = 32;
    localparam int OFFSET_W         = 24;
    localparam int LOG2_W           = 4;
    localparam int BPP_W            = 3;
    localparam int CFG_DATA_W       = 4;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [LOG2_W-1:0] WIDTH_LOG2_RST  = 4'd8;
    localparam logic [LOG2_W-1:0] HEIGHT_LOG2_RST = 4'd8;
    localparam logic [BPP_W-1:0]  BPP_RST         = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIDTH_LOG2  = 2'd0,
        REG_HEIGHT_LOG2 = 2'd1,
        REG_BPP         = 2'd2
    } cfg_index_t;

    // Clamped dimensions (one extra bit so a clamp of 16 still fits) and scale.
    typedef struct packed {
        logic [LOG2_W:0]  wl;
        logic [LOG2_W:0]  hl;
        logic [BPP_W-1:0] bpp;
    } geom_t;

endpackage

// ===== rtl/texture_swizzle_address.sv =====
// Top level: raster pixel stream in, pixel with swizzled byte offset out.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_pixel_value[31:0]
//   m_      | out | m_valid / m_ready  | m_pixel_out[31:0], m_dest_offset[23:0], m_frame_last
//   cfg_    | in  | cfg_wr_en          | cfg_index[1:0], cfg_wdata[3:0]
//
// One word per cycle while m_ready stays high; an input register, then an output
// register, with the interleave, tile add and scale multiply between them.
// Row/column counters advance on each accepted word and wrap after the frame's
// last pixel. Reset clears counters and valids and loads the default geometry.
// A stalled output holds; input stays ready while the first stage can drain.
module texture_swizzle_address #(
    parameter int MAX_DIM_LOG2 = tsa_pkg::MAX_DIM_LOG2_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [tsa_pkg::PIXEL_W-1:0]        s_pixel_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tsa_pkg::PIXEL_W-1:0]        m_pixel_out,
    output logic [tsa_pkg::OFFSET_W-1:0]       m_dest_offset,
    output logic                               m_frame_last
);
    import tsa_pkg::*;

    localparam int DW = MAX_DIM_LOG2;
    localparam logic [LOG2_W:0] MAX_L = (LOG2_W+1)'(MAX_DIM_LOG2);

    logic [LOG2_W-1:0]   width_log2_reg;
    logic [LOG2_W-1:0]   height_log2_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [DW-1:0]       col_reg;
    logic [DW-1:0]       row_reg;
    logic [DW-1:0]       col_next;
    logic [DW-1:0]       row_next;

    logic                st1_valid_reg;
    logic [PIXEL_W-1:0]  st1_pixel_reg;
    logic [DW-1:0]       st1_col_reg;
    logic [DW-1:0]       st1_row_reg;
    logic                st1_last_reg;

    logic                out_valid_reg;
    logic [PIXEL_W-1:0]  out_pixel_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_last_reg;

    geom_t               geom;
    logic [DW-1:0]       wmask;
    logic [DW-1:0]       hmask;
    logic                row_end;
    logic                frame_end;
    logic                s_accept;
    logic                advance;
    logic [OFFSET_W-1:0] offset;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= WIDTH_LOG2_RST;
            height_log2_reg <= HEIGHT_LOG2_RST;
            bpp_reg         <= BPP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH_LOG2:  width_log2_reg  <= cfg_wdata;
                REG_HEIGHT_LOG2: height_log2_reg <= cfg_wdata;
                REG_BPP:         bpp_reg         <= cfg_wdata[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        geom.wl  = ({1'b0, width_log2_reg} > MAX_L) ? MAX_L : {1'b0, width_log2_reg};
        geom.hl  = ({1'b0, height_log2_reg} > MAX_L) ? MAX_L : {1'b0, height_log2_reg};
        geom.bpp = bpp_reg;
        wmask    = ~({DW{1'b1}} << geom.wl);
        hmask    = ~({DW{1'b1}} << geom.hl);
        // a shrunk dimension mid-frame still ends the row/frame
        row_end   = col_reg >= wmask;
        frame_end = row_end && (row_reg >= hmask);
    end

    assign advance  = st1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !st1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (frame_end) begin
            col_next = '0;
            row_next = '0;
        end else if (row_end) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input register: word plus the counts it was taken at
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_pixel_reg <= s_pixel_value;
            st1_col_reg   <= col_reg;
            st1_row_reg   <= row_reg;
            st1_last_reg  <= frame_end;
        end
    end

    tsa_morton #(
        .MAX_DIM_LOG2 (MAX_DIM_LOG2)
    ) u_morton (
        .col    (st1_col_reg),
        .row    (st1_row_reg),
        .geom   (geom),
        .offset (offset)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pixel_reg  <= st1_pixel_reg;
            out_offset_reg <= offset;
            out_last_reg   <= st1_last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_out   = out_pixel_reg;
    assign m_dest_offset = out_offset_reg;
    assign m_frame_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !st1_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !advance) |=> st1_valid_reg)
        else $error("word dropped from input stage");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && frame_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at frame end");

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !row_end) |=> (col_reg == DW'($past(col_reg) + 1'b1)))
        else $error("column count did not advance");
`endif

endmodule

// ===== rtl/tsa_morton.sv =====
// Morton byte offset from column/row counts and the texture geometry.
module tsa_morton #(
    parameter int MAX_DIM_LOG2 = tsa_pkg::MAX_DIM_LOG2_DEF
) (
    input  logic [MAX_DIM_LOG2-1:0]   col,
    input  logic [MAX_DIM_LOG2-1:0]   row,
    input  tsa_pkg::geom_t            geom,
    output logic [tsa_pkg::OFFSET_W-1:0] offset
);
    import tsa_pkg::*;

    localparam int DW = MAX_DIM_LOG2;
    localparam int SW = 2 * DW;
    localparam int SH_W = LOG2_W + 2;

    // Put the bits of v on the even positions.
    function automatic logic [SW-1:0] spread(input logic [DW-1:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int b = 0; b < DW; b++) begin
            r[2*b] = v[b];
        end
        return r;
    endfunction

    logic [DW-1:0]       wmask;
    logic [DW-1:0]       xmask;
    logic [SH_W-1:0]     x_shift;
    logic [OFFSET_W-1:0] sy;
    logic [OFFSET_W-1:0] sx;
    logic [OFFSET_W-1:0] pix_off;
    logic [OFFSET_W-1:0] byte_off;

    always_comb begin
        x_shift  = SH_W'(geom.hl) + SH_W'(1);
        wmask    = ~({DW{1'b1}} << geom.wl);
        xmask    = ~({DW{1'b1}} << x_shift);
        // row bits on odd positions, plus one width*width tile per wrap
        sy       = OFFSET_W'({spread(row & wmask), 1'b0})
                 + (OFFSET_W'(row >> geom.wl) << {geom.wl, 1'b0});
        // column bits on even positions, plus one 2*h*h tile per wrap
        sx       = OFFSET_W'(spread(col & xmask))
                 + (OFFSET_W'(col >> x_shift) << {geom.hl, 1'b1});
        pix_off  = sx + sy;
        byte_off = pix_off * OFFSET_W'(geom.bpp);
        offset   = byte_off;
    end

endmodule
